### sv/lmac_pkg.sv
package lmac_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned QDEPTH    = 8;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_MUL = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_SUB = 2'd2;

  localparam logic REG_MULTIPLIER = 1'b0;
  localparam logic REG_MODE       = 1'b1;
  localparam int unsigned REG_SEL_BIT = 3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } lmac_op_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] src_limb;
    logic [WORD_BITS-1:0] acc_limb;
    logic                 last;
  } lmac_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] result_limb;
    logic [WORD_BITS-1:0] carry_word;
    logic                 last_out;
  } lmac_out_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] carry_lo;
    logic [WORD_BITS-1:0] carry_hi;
    logic                 sub;
    logic                 last;
  } lmac_entry_t;

endpackage

### sv/limb_multiply_accumulate_unit.sv
// an accepted limb passes the three multiply registers, then the queue, then the output register
// throughput: one limb per cycle unless stalled, set by the single add-and-select carry loop
// the multiply runs in a 3-stage pipeline of half-width partial products ahead of an 8-entry queue
// reset clears multiplier, mode, running carry and all valid state at once
// no clearing pass after reset; a limb can be accepted on the first cycle
module limb_multiply_accumulate_unit #(
  parameter int unsigned LIMB_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lmac_pkg::lmac_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lmac_pkg::lmac_out_t  out_data_o
);
  import lmac_pkg::*;

  logic [WORD_BITS-1:0] multiplier_q;
  logic [1:0]           mode_q;
  logic                 cfg_write;
  logic                 accept;

  logic                 push;
  lmac_entry_t          front_entry;
  logic [1:0]           busy;
  lmac_entry_t          q_entry;
  logic                 q_valid;
  logic [QCNT_BITS-1:0] q_count;
  logic                 pop;
  logic [QCNT_BITS:0]   occupancy;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multiplier_q <= '0;
      mode_q       <= MODE_MUL;
    end else if (cfg_write) begin
      unique case (paddr[REG_SEL_BIT])
        REG_MULTIPLIER: multiplier_q <= pwdata;
        REG_MODE:       mode_q       <= pwdata[1:0];
        default:        mode_q       <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_MULTIPLIER: prdata = multiplier_q;
      REG_MODE:       prdata = 64'(mode_q);
      default:        prdata = '0;
    endcase
  end

  // items in flight in the multiplier plus queued ones never exceed the queue depth
  assign occupancy  = (QCNT_BITS+1)'(q_count) + (QCNT_BITS+1)'(busy);
  assign in_stall_o = (occupancy >= (QCNT_BITS+1)'(QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  lmac_front #(
    .LIMB_BITS(LIMB_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .src_limb_i  (in_data_i.src_limb[LIMB_BITS-1:0]),
    .acc_limb_i  (in_data_i.acc_limb[LIMB_BITS-1:0]),
    .last_i      (in_data_i.last),
    .mode_i      (mode_q),
    .multiplier_i(multiplier_q[LIMB_BITS-1:0]),
    .push_o      (push),
    .entry_o     (front_entry),
    .busy_o      (busy)
  );

  lmac_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (front_entry),
    .pop_i      (pop),
    .entry_o    (q_entry),
    .not_empty_o(q_valid),
    .count_o    (q_count)
  );

  lmac_back #(
    .LIMB_BITS(LIMB_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .entry_i    (q_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### sv/lmac_front.sv
module lmac_front #(
  parameter int unsigned LIMB_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [LIMB_BITS-1:0]   src_limb_i,
  input  logic [LIMB_BITS-1:0]   acc_limb_i,
  input  logic                   last_i,
  input  logic [1:0]             mode_i,
  input  logic [LIMB_BITS-1:0]   multiplier_i,
  output logic                   push_o,
  output lmac_pkg::lmac_entry_t  entry_o,
  output logic [1:0]             busy_o
);
  import lmac_pkg::*;

  localparam int unsigned W  = LIMB_BITS;
  localparam int unsigned H  = (LIMB_BITS + 1) / 2;
  localparam int unsigned PW = 4 * H;

  logic [H-1:0] a0, a1, x0, x1;
  lmac_op_e     op_in;

  logic v1_q, v2_q, v3_q;

  logic [2*H-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [W-1:0]   acc1_q, acc2_q, acc3_q;
  logic           last1_q, last2_q, last3_q;
  lmac_op_e       op1_q, op2_q, op3_q;

  logic [2*H:0]   mid_q;
  logic [2*H-1:0] lo2_q, hi2_q;

  logic [PW-1:0]  prod_sum;
  logic [2*W-1:0] prod_q;

  logic [W-1:0] plo, phi, phi_p1, phi_p2;
  logic [W:0]   ext;
  logic         k1;

  assign a0 = src_limb_i[H-1:0];
  assign a1 = H'(src_limb_i >> H);
  assign x0 = multiplier_i[H-1:0];
  assign x1 = H'(multiplier_i >> H);

  // mode three acts as plain multiply
  always_comb begin
    unique case (mode_i)
      MODE_ADD: op_in = OP_ADD;
      MODE_SUB: op_in = OP_SUB;
      default:  op_in = OP_MUL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // partial products
  always_ff @(posedge clk_i) begin
    pp00_q  <= (2*H)'(a0) * (2*H)'(x0);
    pp01_q  <= (2*H)'(a0) * (2*H)'(x1);
    pp10_q  <= (2*H)'(a1) * (2*H)'(x0);
    pp11_q  <= (2*H)'(a1) * (2*H)'(x1);
    acc1_q  <= acc_limb_i;
    last1_q <= last_i;
    op1_q   <= op_in;
  end

  always_ff @(posedge clk_i) begin
    mid_q   <= (2*H+1)'(pp01_q) + (2*H+1)'(pp10_q);
    lo2_q   <= pp00_q;
    hi2_q   <= pp11_q;
    acc2_q  <= acc1_q;
    last2_q <= last1_q;
    op2_q   <= op1_q;
  end

  assign prod_sum = {hi2_q, lo2_q} + (PW'(mid_q) << H);

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_sum[2*W-1:0];
    acc3_q  <= acc2_q;
    last3_q <= last2_q;
    op3_q   <= op2_q;
  end

  assign plo = prod_q[W-1:0];
  assign phi = prod_q[2*W-1:W];

  // fold the accumulator in ahead of the carry loop
  always_comb begin
    unique case (op3_q)
      OP_ADD:  ext = {1'b0, acc3_q} + {1'b0, plo};
      OP_SUB:  ext = {1'b0, acc3_q} - {1'b0, plo};
      default: ext = {1'b0, plo};
    endcase
  end

  assign k1     = ext[W];
  assign phi_p1 = phi + W'(1);
  assign phi_p2 = phi + W'(2);

  always_comb begin
    entry_o.base     = WORD_BITS'(ext[W-1:0]);
    entry_o.carry_lo = WORD_BITS'(k1 ? phi_p1 : phi);
    entry_o.carry_hi = WORD_BITS'(k1 ? phi_p2 : phi_p1);
    entry_o.sub      = (op3_q == OP_SUB);
    entry_o.last     = last3_q;
  end

  assign push_o = v3_q;
  assign busy_o = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

endmodule

### sv/lmac_queue.sv
module lmac_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  lmac_pkg::lmac_entry_t               entry_i,
  input  logic                                pop_i,
  output lmac_pkg::lmac_entry_t               entry_o,
  output logic                                not_empty_o,
  output logic [lmac_pkg::QCNT_BITS-1:0]      count_o
);
  import lmac_pkg::*;

  lmac_entry_t          mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wptr_q, rptr_q;
  logic [QCNT_BITS-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_BITS'(1);
      end
    end
  end

  assign entry_o     = mem_q[rptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q != QCNT_BITS'(QDEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue underflow");

endmodule

### sv/lmac_back.sv
module lmac_back #(
  parameter int unsigned LIMB_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  lmac_pkg::lmac_entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lmac_pkg::lmac_out_t   out_data_o
);
  import lmac_pkg::*;

  localparam int unsigned W = LIMB_BITS;

  logic [W-1:0] carry_q, carry_d;
  logic         out_valid_q;
  lmac_out_t    out_q;

  logic [W-1:0] base;
  logic [W:0]   ext;
  logic         k2;
  logic [W-1:0] c_next;

  assign base = entry_i.base[W-1:0];

  // carry loop: one add or subtract, then pick the precomputed high word
  always_comb begin
    if (entry_i.sub) begin
      ext = {1'b0, base} - {1'b0, carry_q};
    end else begin
      ext = {1'b0, base} + {1'b0, carry_q};
    end
  end

  assign k2     = ext[W];
  assign c_next = k2 ? entry_i.carry_hi[W-1:0] : entry_i.carry_lo[W-1:0];
  assign pop_o  = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    carry_d = carry_q;
    if (pop_o) begin
      carry_d = entry_i.last ? '0 : c_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      carry_q     <= carry_d;
      out_valid_q <= pop_o || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.result_limb <= WORD_BITS'(ext[W-1:0]);
      out_q.carry_word  <= entry_i.last ? WORD_BITS'(c_next) : '0;
      out_q.last_out    <= entry_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_carry_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.last) |=> (carry_q == '0))
    else $error("carry not cleared after last limb");

  a_carry_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last_out) |-> (out_q.carry_word == '0))
    else $error("carry word set on a limb that is not last");

endmodule

### tb/sv/limb_multiply_accumulate_unit_tb.sv
module limb_multiply_accumulate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmac_pkg::*;

  localparam logic [1:0]  MODE_RSVD   = 2'd3;
  localparam logic [3:0]  ADDR_MULT   = 4'(32'(REG_MULTIPLIER) << REG_SEL_BIT);
  localparam logic [3:0]  ADDR_MODE   = 4'(32'(REG_MODE) << REG_SEL_BIT);
  localparam logic [63:0] ALL_ONES    = '1;
  localparam logic [63:0] TOP_BIT     = 64'h8000_0000_0000_0000;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned END_WAIT    = 20;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [1:0]  MODE_CYCLE [4] = '{MODE_MUL, MODE_ADD, MODE_SUB, MODE_RSVD};

  typedef struct packed {
    logic [63:0] mult;
    logic [1:0]  mode;
    lmac_in_t    beat;
    logic        typed;
    lmac_out_t   want;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  lmac_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  lmac_out_t   out_data_o;

  logic [63:0] mult_cfg  = '0;
  logic [1:0]  mode_cfg  = MODE_MUL;
  logic [63:0] carry_run = '0;

  lmac_out_t   pending_results [$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  bit          quiet        = 1'b0;
  bit          hold_rx      = 1'b0;

  dir_row_t dir_rows [20] = '{
    '{'0,       MODE_MUL,  '{ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{64'h0, 64'h0, 1'b1}},
    '{ALL_ONES, MODE_MUL,  '{ALL_ONES, 64'h0, 1'b0},    1'b1, '{64'h1, 64'h0, 1'b0}},
    '{ALL_ONES, MODE_MUL,  '{ALL_ONES, 64'h0, 1'b1},    1'b1,
      '{ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1}},
    '{ALL_ONES, MODE_MUL,  '{64'h0, ALL_ONES, 1'b1},    1'b1, '{64'h0, 64'h0, 1'b1}},
    '{ALL_ONES, MODE_ADD,  '{ALL_ONES, ALL_ONES, 1'b0}, 1'b0, '0},
    '{ALL_ONES, MODE_ADD,  '{ALL_ONES, ALL_ONES, 1'b1}, 1'b0, '0},
    '{ALL_ONES, MODE_ADD,  '{64'h0, ALL_ONES, 1'b1},    1'b1, '{ALL_ONES, 64'h0, 1'b1}},
    '{ALL_ONES, MODE_SUB,  '{ALL_ONES, 64'h0, 1'b0},    1'b0, '0},
    '{ALL_ONES, MODE_SUB,  '{ALL_ONES, 64'h0, 1'b1},    1'b0, '0},
    '{ALL_ONES, MODE_SUB,  '{64'h0, 64'h0, 1'b1},       1'b1, '{64'h0, 64'h0, 1'b1}},
    '{TOP_BIT | 64'h1, MODE_RSVD, '{ALL_ONES, 64'h0123_4567_89AB_CDEF, 1'b0}, 1'b0, '0},
    '{TOP_BIT | 64'h1, MODE_RSVD, '{64'h1, ALL_ONES, 1'b1}, 1'b0, '0},
    '{64'h1, MODE_ADD, '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1}, 1'b1,
      '{ALL_ONES, 64'h0, 1'b1}},
    '{64'h1, MODE_ADD, '{64'h1, ALL_ONES, 1'b1}, 1'b1, '{64'h0, 64'h1, 1'b1}},
    '{64'h1, MODE_SUB, '{64'h1, 64'h0, 1'b1},    1'b1, '{ALL_ONES, 64'h1, 1'b1}},
    '{TOP_BIT, MODE_MUL, '{64'h2, 64'h0, 1'b0},  1'b1, '{64'h0, 64'h0, 1'b0}},
    '{TOP_BIT, MODE_MUL, '{64'h0, 64'h0, 1'b1},  1'b1, '{64'h1, 64'h0, 1'b1}},
    '{64'hAAAA_AAAA_AAAA_AAAA, MODE_MUL, '{64'h0F0F_0F0F_0F0F_0F0F, 64'h0, 1'b0}, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, MODE_MUL, '{64'hF0F0_F0F0_F0F0_F0F0, 64'h0, 1'b0}, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, MODE_MUL, '{64'h1234_5678_9ABC_DEF0, ALL_ONES, 1'b1}, 1'b0, '0}
  };

  limb_multiply_accumulate_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // next result limb and carry, advancing the running carry
  function automatic lmac_out_t mac_limb(lmac_in_t b);
    logic [127:0] prod;
    logic [64:0]  sum;
    logic [63:0]  lo;
    logic [63:0]  r;
    logic [63:0]  c;
    lmac_out_t    o;
    prod = 128'(b.src_limb) * 128'(mult_cfg);
    sum  = {1'b0, prod[63:0]} + {1'b0, carry_run};
    lo   = sum[63:0];
    c    = prod[127:64] + 64'(sum[64]);
    case (mode_cfg)
      MODE_ADD: begin
        sum = {1'b0, b.acc_limb} + {1'b0, lo};
        r   = sum[63:0];
        c   = c + 64'(sum[64]);
      end
      MODE_SUB: begin
        r = b.acc_limb - lo;
        c = c + 64'(lo > b.acc_limb);
      end
      default: begin
        r = lo;
      end
    endcase
    o.result_limb = r;
    o.carry_word  = b.last ? c : '0;
    o.last_out    = b.last;
    carry_run     = b.last ? '0 : c;
    return o;
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 15));
      3: return TOP_BIT | 64'($urandom);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] exp,
                               input logic [63:0] act);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch in %s: expected %h, got %h", what, exp, act);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [63:0] wdata,
                            output logic [63:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stop offering limbs and wait for every outstanding result beat
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] mult, input logic [1:0] mode);
    logic [63:0] rd;
    settle();
    apb_access(1'b1, ADDR_MULT, mult, rd);
    apb_access(1'b1, ADDR_MODE, 64'(mode), rd);
    mult_cfg = mult;
    mode_cfg = mode;
    apb_access(1'b0, ADDR_MULT, '0, rd);
    if (rd !== mult) note_mismatch("multiplier readback", mult, rd);
    apb_access(1'b0, ADDR_MODE, '0, rd);
    if (rd[1:0] !== mode) note_mismatch("mode readback", 64'(mode), 64'(rd[1:0]));
  endtask

  task automatic send_limb(input lmac_in_t b, input logic typed, input lmac_out_t want);
    int unsigned gap;
    lmac_out_t   got;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    got = mac_limb(b);
    pending_results.push_back(typed ? want : got);
  endtask

  // result side: random stall per beat outside quiet phases, plus one long hold-off on request
  initial begin
    int unsigned gap;
    forever begin
      if (hold_rx) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold_rx = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    lmac_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result beat with nothing expected", '0, out_data_o.result_limb);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.result_limb !== want.result_limb)
          note_mismatch("result_limb", want.result_limb, out_data_o.result_limb);
        if (out_data_o.carry_word !== want.carry_word)
          note_mismatch("carry_word", want.carry_word, out_data_o.carry_word);
        if (out_data_o.last_out !== want.last_out)
          note_mismatch("last_out", 64'(want.last_out), 64'(out_data_o.last_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    lmac_in_t    b;
    logic [63:0] m;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mult != mult_cfg || dir_rows[i].mode != mode_cfg) begin
        set_config(dir_rows[i].mult, dir_rows[i].mode);
      end
      send_limb(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      m = (ph == 0) ? ALL_ONES : (ph == 1) ? '0 : pick_word();
      quiet = (ph % 3 == 2);
      set_config(m, MODE_CYCLE[ph % 4]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 20) hold_rx = 1'b1;
        if (ph == 6 && k == 60) settle();
        b.src_limb = pick_word();
        b.acc_limb = pick_word();
        b.last     = ($urandom_range(0, 5) == 0);
        send_limb(b, 1'b0, '0);
      end
    end

    settle();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### limb_multiply_accumulate_unit.f
sv/lmac_pkg.sv
sv/lmac_front.sv
sv/lmac_queue.sv
sv/lmac_back.sv
sv/limb_multiply_accumulate_unit.sv
tb/sv/limb_multiply_accumulate_unit_tb.sv
